// ===== sv/u8u16_pkg.sv =====
`default_nettype none

package u8u16_pkg;

   localparam int unsigned MaxUnits = 4;

   localparam logic [15:0] ReplChar     = 16'hFFFD;
   localparam logic [15:0] HighSurrBase = 16'hD800;
   localparam logic [15:0] LowSurrBase  = 16'hDC00;
   localparam logic [20:0] SurrFirst    = 21'h00D800;
   localparam logic [20:0] SurrLast     = 21'h00DFFF;
   localparam logic [20:0] PlaneOneBase = 21'h010000;
   localparam logic [20:0] MaxCodePoint = 21'h10FFFF;
   localparam logic [20:0] MinTwoByte   = 21'h000080;
   localparam logic [20:0] MinThreeByte = 21'h000800;

   localparam logic [7:0] Lead2Mask  = 8'hE0;
   localparam logic [7:0] Lead2Code  = 8'hC0;
   localparam logic [7:0] Lead3Mask  = 8'hF0;
   localparam logic [7:0] Lead3Code  = 8'hE0;
   localparam logic [7:0] Lead4Mask  = 8'hF8;
   localparam logic [7:0] Lead4Code  = 8'hF0;
   localparam logic [7:0] ContMask   = 8'hC0;
   localparam logic [7:0] ContCode   = 8'h80;

   // One decoded byte's worth of code units, handed to the output buffer.
   typedef struct packed {
      logic                  valid;
      logic [MaxUnits-1:0][15:0] units;
      logic [2:0]            count;
      logic                  msg_end;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/u8u16_channels.sv =====
`default_nettype none

interface u8u16_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       message_end;

   modport source (output valid, output in_byte, output message_end, input ready);
   modport sink   (input valid, input in_byte, input message_end, output ready);
endinterface

interface u8u16_unit_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        item_done;
   logic        message_done;

   modport source (output valid, output code_unit, output item_done, output message_done,
                   input ready);
   modport sink   (input valid, input code_unit, input item_done, input message_done,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/u8u16_decoder.sv =====
`default_nettype none

module u8u16_decoder
   import u8u16_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   u8u16_byte_if.sink   req_if,
   input  wire logic    load_ok,
   output result_type   result
);

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;

   logic [7:0]  lead_ff, lead_in;
   logic [17:0] gbits_ff, gbits_in;
   logic [1:0]  expect_ff, expect_in;
   logic [1:0]  got_ff, got_in;

   logic        advance;
   logic [1:0]  f_need;
   logic        f_emit;
   logic [15:0] f_unit;
   logic        is_cont;
   logic [2:0]  got_next;
   logic [17:0] gbits_new;
   logic [20:0] cp_value;
   logic        cp_ok;
   logic [19:0] cp_adj;
   logic [MaxUnits-1:0][15:0] units;
   logic [2:0]  count;

   // Classify the held byte as if the decoder were idle.
   always_comb begin
      if ((s1_byte_ff & Lead2Mask) == Lead2Code) begin
         f_need = 2'd1;
      end else if ((s1_byte_ff & Lead3Mask) == Lead3Code) begin
         f_need = 2'd2;
      end else if ((s1_byte_ff & Lead4Mask) == Lead4Code) begin
         f_need = 2'd3;
      end else begin
         f_need = 2'd0;
      end
      f_emit = !s1_byte_ff[7] || (f_need == 2'd0) || s1_last_ff;
      f_unit = s1_byte_ff[7] ? ReplChar : {8'h00, s1_byte_ff};
   end

   assign is_cont   = (s1_byte_ff & ContMask) == ContCode;
   assign got_next  = {1'b0, got_ff} + 3'd1;
   assign gbits_new = {gbits_ff[11:0], s1_byte_ff[5:0]};
   assign cp_adj    = 20'(cp_value - PlaneOneBase);

   always_comb begin
      case (expect_ff)
         2'd1: begin
            cp_value = {10'd0, lead_ff[4:0], gbits_new[5:0]};
            cp_ok    = cp_value >= MinTwoByte;
         end
         2'd2: begin
            cp_value = {5'd0, lead_ff[3:0], gbits_new[11:0]};
            cp_ok    = (cp_value >= MinThreeByte) &&
                       !((cp_value >= SurrFirst) && (cp_value <= SurrLast));
         end
         default: begin
            cp_value = {lead_ff[2:0], gbits_new};
            cp_ok    = (cp_value >= PlaneOneBase) && (cp_value <= MaxCodePoint);
         end
      endcase
   end

   always_comb begin
      lead_in   = lead_ff;
      gbits_in  = gbits_ff;
      expect_in = expect_ff;
      got_in    = got_ff;
      units     = {MaxUnits{ReplChar}};
      count     = 3'd0;
      if (expect_ff == 2'd0) begin
         if (f_emit) begin
            units[0] = f_unit;
            count    = 3'd1;
         end else begin
            lead_in   = s1_byte_ff;
            gbits_in  = '0;
            expect_in = f_need;
            got_in    = 2'd0;
         end
      end else if (is_cont) begin
         if (got_next >= {1'b0, expect_ff}) begin
            // Sequence complete: check the value, split above the BMP.
            if (!cp_ok) begin
               count = {1'b0, expect_ff} + 3'd1;
            end else if (cp_value[20:16] == 5'd0) begin
               units[0] = cp_value[15:0];
               count    = 3'd1;
            end else begin
               units[0] = HighSurrBase | {6'd0, cp_adj[19:10]};
               units[1] = LowSurrBase  | {6'd0, cp_adj[9:0]};
               count    = 3'd2;
            end
            lead_in   = '0;
            gbits_in  = '0;
            expect_in = 2'd0;
            got_in    = 2'd0;
         end else if (s1_last_ff) begin
            count     = got_next + 3'd1;
            lead_in   = '0;
            gbits_in  = '0;
            expect_in = 2'd0;
            got_in    = 2'd0;
         end else begin
            gbits_in = gbits_new;
            got_in   = got_next[1:0];
         end
      end else begin
         // Broken sequence: drop it, then decode this byte afresh.
         count     = {1'b0, got_ff} + 3'd1;
         lead_in   = '0;
         gbits_in  = '0;
         expect_in = 2'd0;
         got_in    = 2'd0;
         if (f_emit) begin
            units[got_ff + 2'd1] = f_unit;
            count                = {1'b0, got_ff} + 3'd2;
         end else begin
            lead_in   = s1_byte_ff;
            expect_in = f_need;
         end
      end
   end

   assign advance      = s1_valid_ff && ((count == 3'd0) || load_ok);
   assign req_if.ready = !s1_valid_ff || advance;
   assign s1_valid_in  = req_if.valid || (s1_valid_ff && !advance);

   assign result.valid   = s1_valid_ff && (count != 3'd0);
   assign result.units   = units;
   assign result.count   = count;
   assign result.msg_end = s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         lead_ff     <= '0;
         gbits_ff    <= '0;
         expect_ff   <= 2'd0;
         got_ff      <= 2'd0;
      end else begin
         if (req_if.ready) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (advance) begin
            lead_ff   <= lead_in;
            gbits_ff  <= gbits_in;
            expect_ff <= expect_in;
            got_ff    <= got_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_byte_ff <= req_if.in_byte;
         s1_last_ff <= req_if.message_end;
      end
   end

endmodule

`default_nettype wire

// ===== sv/u8u16_unit_buffer.sv =====
`default_nettype none

module u8u16_unit_buffer
   import u8u16_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire result_type result,
   output logic         load_ok,
   u8u16_unit_if.source rsp_if
);

   logic [MaxUnits-1:0][15:0] units_ff;
   logic [2:0]  remain_ff, remain_in;
   logic [1:0]  index_ff, index_in;
   logic        last_ff;
   logic        fire;

   assign fire    = rsp_if.valid && rsp_if.ready;
   assign load_ok = (remain_ff == 3'd0) || ((remain_ff == 3'd1) && rsp_if.ready);

   always_comb begin
      remain_in = remain_ff;
      index_in  = index_ff;
      if (result.valid && load_ok) begin
         remain_in = result.count;
         index_in  = 2'd0;
      end else if (fire) begin
         remain_in = remain_ff - 3'd1;
         index_in  = index_ff + 2'd1;
      end
   end

   assign rsp_if.valid        = remain_ff != 3'd0;
   assign rsp_if.code_unit    = units_ff[index_ff];
   assign rsp_if.item_done    = remain_ff == 3'd1;
   assign rsp_if.message_done = (remain_ff == 3'd1) && last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= 3'd0;
         index_ff  <= 2'd0;
      end else begin
         remain_ff <= remain_in;
         index_ff  <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid && load_ok) begin
         units_ff <= result.units;
         last_ff  <= result.msg_end;
      end
   end

endmodule

`default_nettype wire

// ===== sv/utf8_to_utf16le_transcoder.sv =====
// Path: a byte accepted into the input register is decoded combinationally; its first code
//   unit is presented on rsp_if once the result buffer has registered the decoded units.
// Throughput: one byte per cycle while the result buffer can load; a byte that yields k code
//   units (k up to 4) stalls the next byte while the buffer drains, a byte that yields none never.
// Reset: synchronous, active high; clears the open sequence and empties both stages.
`default_nettype none

module utf8_to_utf16le_transcoder
   import u8u16_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   u8u16_byte_if.sink   req_if,
   u8u16_unit_if.source rsp_if
);

   // Decoder result handed to the output buffer, one transaction's worth of units.
   result_type result;
   // Buffer can take a new result this cycle (empty, or last unit leaving now).
   logic       load_ok;

   // Input register plus sequence state; decodes one byte per cycle while the buffer can take its result.
   u8u16_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .load_ok (load_ok),
      .result  (result)
   );

   // Result register; serializes the units of one byte onto the output channel.
   u8u16_unit_buffer u_unit_buffer (
      .clock   (clock),
      .reset   (reset),
      .result  (result),
      .load_ok (load_ok),
      .rsp_if  (rsp_if)
   );

endmodule

`default_nettype wire
